>>> sv/ttce_pkg.sv
// Package for the text terminal character engine: item structs, character
// and register codes, and the cell packing function. No dependencies.
`default_nettype none

package ttce_pkg;

  // Fixed field widths of the item channels.
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned CELL_W   = 16;

  // Saturation value of the typed-character count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // Item modes.
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Character codes with a control meaning.
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Cell value after reset: a space, white on black.
  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0F20;

  // Configuration register indexes.
  localparam logic CFG_FILL_FG = 1'b0;
  localparam logic CFG_FILL_BG = 1'b1;

  // One input item.
  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
    logic [10:0] cell_index;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [6:0]  column;
    logic [4:0]  line_row;
    logic [10:0] line_count;
    logic [15:0] cell_data;
  } out_item_t;

  // What a put item asks of the cell store.
  typedef struct packed {
    logic wr_en;
    logic wr_blank;
    logic scroll;
  } put_act_t;

  // Pack a character and its colors into one cell.
  function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch,
                                                  input logic [3:0] fg,
                                                  input logic [3:0] bg);
    return {bg, fg, ch};
  endfunction

endpackage

`default_nettype wire

>>> sv/ttce_cell_mem.sv
// Cell store of the text terminal engine: one write port and one read port
// with registered read data. Depends on ttce_pkg for the cell width.
`default_nettype none

module ttce_cell_mem #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  wire                               clk,
  input  wire                               we,
  input  wire  [AW-1:0]                     waddr,
  input  wire  [ttce_pkg::CELL_W-1:0]       wdata,
  input  wire                               re,
  input  wire  [AW-1:0]                     raddr,
  output logic [ttce_pkg::CELL_W-1:0]       rdata
);

  logic [ttce_pkg::CELL_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/ttce_cursor.sv
// Cursor and line-count state of the text terminal engine, with the
// next-state logic for put items. Depends on ttce_pkg.
`default_nettype none

module ttce_cursor #(
  parameter int unsigned COLS      = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned KEEP_ROWS = 10,
  parameter int unsigned TAB_STOP  = 4
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          step,
  input  wire  [7:0]                                   char_code,
  output ttce_pkg::put_act_t                           act,
  output logic [$clog2(COLS*ROWS)-1:0]                 wr_addr,
  output logic [$clog2(COLS*ROWS+TAB_STOP+1)-1:0]      cur_lin,
  output logic [$clog2(COLS+TAB_STOP)-1:0]             cur_col,
  output logic [$clog2(ROWS+1)-1:0]                    cur_row,
  output logic [ttce_pkg::COUNT_W-1:0]                 cur_cnt
);

  localparam int unsigned NCELLS   = COLS * ROWS;
  localparam int unsigned KEEP_EFF = (KEEP_ROWS < ROWS) ? KEEP_ROWS : ROWS - 1;
  localparam int unsigned AW       = $clog2(NCELLS);
  localparam int unsigned LW       = $clog2(NCELLS + TAB_STOP + 1);
  localparam int unsigned CW       = $clog2(COLS + TAB_STOP);
  localparam int unsigned RW       = $clog2(ROWS + 1);
  localparam int unsigned PW       = $clog2(TAB_STOP + 1);
  localparam int unsigned CNTW     = ttce_pkg::COUNT_W;
  localparam int unsigned XW       = (LW > CNTW) ? LW : CNTW;
  localparam int unsigned PH_LAST  = (COLS - 1) % TAB_STOP;

  logic [LW-1:0]   lin_r, lin_a, lin_w, lin_nxt;
  logic [CW-1:0]   col_r, col_a, col_w, col_nxt;
  logic [RW-1:0]   row_r, row_a, row_w, row_nxt;
  logic [CNTW-1:0] cnt_r, cnt_a, cnt_nxt;
  logic [PW-1:0]   ph_r, ph_a, ph_w, ph_nxt;
  logic [PW-1:0]   tab_n;
  logic [CNTW:0]   sum_one, sum_tab;
  logic [CNTW-1:0] cnt_one, cnt_tab;
  logic            wr_en_a, wr_blank_a, scroll_w;

  // The column modulo the tab stop is kept as its own register, so the
  // tab distance needs no divider.
  assign tab_n   = PW'(TAB_STOP) - ph_r;
  assign sum_one = {1'b0, cnt_r} + (CNTW+1)'(1);
  assign sum_tab = {1'b0, cnt_r} + (CNTW+1)'(tab_n);
  assign cnt_one = sum_one[CNTW] ? ttce_pkg::COUNT_MAX : sum_one[CNTW-1:0];
  assign cnt_tab = sum_tab[CNTW] ? ttce_pkg::COUNT_MAX : sum_tab[CNTW-1:0];

  // Effect of the character itself.
  always_comb begin
    lin_a      = lin_r;
    col_a      = col_r;
    row_a      = row_r;
    cnt_a      = cnt_r;
    ph_a       = ph_r;
    wr_en_a    = 1'b0;
    wr_blank_a = 1'b0;
    wr_addr    = lin_r[AW-1:0];
    unique case (char_code)
      ttce_pkg::CH_NEWLINE: begin
        row_a = row_r + RW'(1);
        col_a = '0;
        lin_a = lin_r - LW'(col_r) + LW'(COLS);
        cnt_a = '0;
        ph_a  = '0;
      end
      ttce_pkg::CH_BACKSPACE: begin
        if (lin_r != '0 && cnt_r != '0) begin
          lin_a      = lin_r - LW'(1);
          cnt_a      = cnt_r - CNTW'(1);
          wr_en_a    = 1'b1;
          wr_blank_a = 1'b1;
          wr_addr    = lin_a[AW-1:0];
          if (col_r == '0) begin
            row_a = row_r - RW'(1);
            col_a = CW'(COLS - 1);
            ph_a  = PW'(PH_LAST);
          end else begin
            col_a = col_r - CW'(1);
            ph_a  = (ph_r == '0) ? PW'(TAB_STOP - 1) : ph_r - PW'(1);
          end
        end
      end
      ttce_pkg::CH_TAB: begin
        col_a = col_r + CW'(tab_n);
        lin_a = lin_r + LW'(tab_n);
        cnt_a = cnt_tab;
        ph_a  = '0;
      end
      default: begin
        wr_en_a = 1'b1;
        col_a   = col_r + CW'(1);
        lin_a   = lin_r + LW'(1);
        cnt_a   = cnt_one;
        ph_a    = (ph_r == PW'(TAB_STOP - 1)) ? '0 : ph_r + PW'(1);
      end
    endcase
  end

  // Column wrap onto the next row.
  always_comb begin
    lin_w = lin_a;
    col_w = col_a;
    row_w = row_a;
    ph_w  = ph_a;
    if (col_a >= CW'(COLS)) begin
      row_w = row_a + RW'(1);
      col_w = '0;
      lin_w = lin_a - LW'(col_a) + LW'(COLS);
      ph_w  = '0;
    end
  end

  // Scroll: the cursor lands on the first blanked row and the count is
  // clipped to the new linear position.
  always_comb begin
    scroll_w = (row_w >= RW'(ROWS));
    lin_nxt  = lin_w;
    col_nxt  = col_w;
    row_nxt  = row_w;
    cnt_nxt  = cnt_a;
    ph_nxt   = ph_w;
    if (scroll_w) begin
      row_nxt = RW'(KEEP_EFF);
      lin_nxt = LW'(KEEP_EFF * COLS) + LW'(col_w);
      if (XW'(lin_nxt) < XW'(cnt_a)) begin
        cnt_nxt = CNTW'(lin_nxt);
      end
    end
  end

  // What the item asks of the cell store.
  assign act = '{wr_en: wr_en_a, wr_blank: wr_blank_a, scroll: scroll_w};

  // Cursor registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r <= '0;
      col_r <= '0;
      row_r <= '0;
      cnt_r <= '0;
      ph_r  <= '0;
    end else if (step) begin
      lin_r <= lin_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      cnt_r <= cnt_nxt;
      ph_r  <= ph_nxt;
    end
  end

  assign cur_lin = lin_r;
  assign cur_col = col_r;
  assign cur_row = row_r;
  assign cur_cnt = cnt_r;

`ifndef SYNTHESIS
  // The linear cursor always agrees with row and column.
  a_lin_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    lin_r == LW'(row_r * COLS) + LW'(col_r))
    else $error("linear cursor disagrees with row and column");

  // Between items the cursor is always on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < CW'(COLS) && row_r < RW'(ROWS))
    else $error("cursor left the screen");

  // A scrolling item leaves the cursor on the first blanked row.
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (step && act.scroll) |=> row_r == RW'(KEEP_EFF))
    else $error("cursor not on the first blanked row after a scroll");
`endif

endmodule

`default_nettype wire

>>> sv/text_terminal_char_engine.sv
// Top level of the text terminal character engine: control sequencer,
// fill-color registers and result register. Depends on ttce_pkg,
// ttce_cell_mem and ttce_cursor.
//
// Usage: present an item on in_item and raise start; it is taken at a clock
// edge where busy is low. A put item (mode 0) draws a character or acts on
// newline, backspace or tab; a read item (mode 1) returns one cell. Every
// item gives exactly one result on out_item, shown for one cycle with
// out_valid high; the receiver cannot hold it off.
// Latency and throughput: a put item that does not scroll writes its cell
// (if any) at the accepting edge and its result appears the next cycle, so
// such items go at one per cycle. A read item reads the cell store at the
// accepting edge, then the read state registers the result, with busy high.
// A put item that scrolls runs one copy-and-blank sweep over the cell store,
// one write per cycle through the single write port, with busy high.
// Reset: the cursor and count clear at once, then a clearing pass writes
// every cell blank with busy high.
// Configuration writes (cfg_we) are taken on any cycle, but should only
// be made while no item is in progress.
`default_nettype none

module text_terminal_char_engine #(
  parameter int unsigned COLS      = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned KEEP_ROWS = 10,
  parameter int unsigned TAB_STOP  = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  ttce_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output ttce_pkg::out_item_t  out_item,
  input  wire                  cfg_we,
  input  wire                  cfg_index,
  input  wire  [3:0]           cfg_data
);

  localparam int unsigned NCELLS     = COLS * ROWS;
  localparam int unsigned KEEP_EFF   = (KEEP_ROWS < ROWS) ? KEEP_ROWS : ROWS - 1;
  localparam int unsigned KEEP_CELLS = COLS * KEEP_EFF;
  localparam int unsigned DELTA      = COLS * (ROWS - KEEP_EFF);
  localparam int unsigned AW         = $clog2(NCELLS);
  localparam int unsigned LW         = $clog2(NCELLS + TAB_STOP + 1);
  localparam int unsigned CW         = $clog2(COLS + TAB_STOP);
  localparam int unsigned RW         = $clog2(ROWS + 1);
  localparam int unsigned SW         = $clog2(NCELLS + 1);
  localparam int unsigned IXW        = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int unsigned CELLW      = ttce_pkg::CELL_W;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_READ   = 4'b0100,
    ST_SCROLL = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [SW-1:0]                   sweep_r, sweep_nxt;
  logic [SW-1:0]                   sweep_prev;
  logic                            out_valid_r, out_valid_nxt;
  logic [CELLW-1:0]                cell_data_r, cell_data_nxt;
  logic                            rd_oob_r, rd_oob_nxt;
  logic [3:0]                      fill_fg_r, fill_bg_r;

  logic                            accept, put_step;
  logic [IXW-1:0]                  idx_ext;
  logic                            idx_oob;
  logic [CELLW-1:0]                blank_cell;

  ttce_pkg::put_act_t              act;
  logic [AW-1:0]                   put_addr;
  logic [LW-1:0]                   cur_lin;
  logic [CW-1:0]                   cur_col;
  logic [RW-1:0]                   cur_row;
  logic [ttce_pkg::COUNT_W-1:0]    cur_cnt;

  logic                            mem_we, mem_re;
  logic [AW-1:0]                   mem_waddr, mem_raddr;
  logic [CELLW-1:0]                mem_wdata, mem_rdata;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign put_step   = accept && (in_item.mode == ttce_pkg::MODE_PUT);
  assign idx_ext    = IXW'(in_item.cell_index);
  assign idx_oob    = (idx_ext >= IXW'(NCELLS));
  assign blank_cell = ttce_pkg::make_cell(ttce_pkg::CH_SPACE, fill_fg_r, fill_bg_r);
  assign sweep_prev = sweep_r - SW'(1);

  ttce_cursor #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .KEEP_ROWS (KEEP_ROWS),
    .TAB_STOP  (TAB_STOP)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (put_step),
    .char_code (in_item.char_code),
    .act       (act),
    .wr_addr   (put_addr),
    .cur_lin   (cur_lin),
    .cur_col   (cur_col),
    .cur_row   (cur_row),
    .cur_cnt   (cur_cnt)
  );

  ttce_cell_mem #(
    .DEPTH (NCELLS),
    .AW    (AW)
  ) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer: clearing pass, item acceptance, read return, scroll sweep.
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = 1'b0;
    cell_data_nxt = cell_data_r;
    rd_oob_nxt    = rd_oob_r;
    mem_we        = 1'b0;
    mem_waddr     = put_addr;
    mem_wdata     = blank_cell;
    mem_re        = 1'b0;
    mem_raddr     = idx_ext[AW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(sweep_r);
        mem_wdata = ttce_pkg::CELL_RESET;
        if (sweep_r == SW'(NCELLS - 1)) begin
          sweep_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + SW'(1);
        end
      end
      ST_IDLE: begin
        if (put_step) begin
          mem_we        = act.wr_en;
          mem_waddr     = put_addr;
          mem_wdata     = act.wr_blank ? blank_cell :
                          ttce_pkg::make_cell(in_item.char_code, in_item.fg_color,
                                              in_item.bg_color);
          cell_data_nxt = '0;
          if (act.scroll) begin
            sweep_nxt = '0;
            state_nxt = ST_SCROLL;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end else if (accept) begin
          mem_re     = 1'b1;
          rd_oob_nxt = idx_oob;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        cell_data_nxt = rd_oob_r ? '0 : mem_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCROLL: begin
        // Read the source cell of the kept rows in the cycle before its write.
        if (sweep_r < SW'(KEEP_CELLS)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(sweep_r + SW'(DELTA));
        end
        if (sweep_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(sweep_prev);
          mem_wdata = (sweep_prev < SW'(KEEP_CELLS)) ? mem_rdata : blank_cell;
        end
        if (sweep_r == SW'(NCELLS)) begin
          sweep_nxt     = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + SW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and read bookkeeping.
  always_ff @(posedge clk) begin
    cell_data_r <= cell_data_nxt;
    rd_oob_r    <= rd_oob_nxt;
  end

  // Fill-color registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_fg_r <= 4'd15;
      fill_bg_r <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttce_pkg::CFG_FILL_FG: fill_fg_r <= cfg_data;
        ttce_pkg::CFG_FILL_BG: fill_bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result item: the cursor registers already hold the post-item state.
  assign out_valid = out_valid_r;
  assign out_item  = '{cursor_pos: 11'(cur_lin),
                       column:     7'(cur_col),
                       line_row:   5'(cur_row),
                       line_count: cur_cnt,
                       cell_data:  cell_data_r};

`ifndef SYNTHESIS
  // Every accepted item either shows its result next cycle or holds busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted item neither finished nor in progress");

  // A read item always moves to the read return state.
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.mode == ttce_pkg::MODE_READ) |=> state_r == ST_READ)
    else $error("read item did not enter the read state");

  // A result is only shown once the sequencer is back to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_IDLE)
    else $error("result shown while the sequencer is busy");

  // The read return state yields a result in the cycle after it.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid)
    else $error("read state did not yield a result");
`endif

endmodule

`default_nettype wire
